### rtl/gqlay_pkg.sv
// Shared types and constants for the glyph quad layout block.
// No dependencies; the front end, queue, back end, top level and testbench import it.
`default_nettype none

package gqlay_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int MAX_CHARS   = 128;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
  localparam int SEEN_W      = $clog2(MAX_CHARS + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 24;

  localparam logic [15:0] ASCENT_RESET    = 16'd2816;
  localparam logic [15:0] LINE_DIST_RESET = 16'd4096;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ASCENT    = 2'd0;
  localparam cfg_idx_t REG_LINE_DIST = 2'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef struct packed {
    logic signed [7:0] bx;
    logic signed [8:0] by;
    logic [7:0]        w;
    logic [7:0]        h;
    logic [13:0]       adv;
  } geom_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] bottom;
  } tex_t;

  localparam int GEOM_W = $bits(geom_t);
  localparam int TEX_W  = $bits(tex_t);

  typedef struct packed {
    logic  reset_pen;
    logic  newline;
    geom_t geom;
    tex_t  tex;
  } q_entry_t;

  typedef struct packed {
    logic                  we;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GLYPH,
    BK_NEWLINE
  } back_state_t;

endpackage

`default_nettype wire

### rtl/gqlay_if.sv
// Request channel interfaces of the glyph quad layout block.
// Depends on nothing; payload widths follow the field list.
`default_nettype none

interface gqlay_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic              first_of_string;
  logic [7:0]        char_code;
  logic signed [7:0] bearing_x;
  logic signed [8:0] bearing_y;
  logic [7:0]        glyph_width;
  logic [7:0]        glyph_height;
  logic [13:0]       advance;
  logic [15:0]       tex_left;
  logic [15:0]       tex_right;
  logic [15:0]       tex_top;
  logic [15:0]       tex_bottom;

  modport source (
    output valid, operation, first_of_string, char_code, bearing_x, bearing_y,
           glyph_width, glyph_height, advance, tex_left, tex_right, tex_top,
           tex_bottom,
    input  ready
  );
  modport sink (
    input  valid, operation, first_of_string, char_code, bearing_x, bearing_y,
           glyph_width, glyph_height, advance, tex_left, tex_right, tex_top,
           tex_bottom,
    output ready
  );
endinterface

interface gqlay_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [1:0]         corner;
  logic               last;

  modport source (
    output valid, pos_x, pos_y, tex_u, tex_v, corner, last,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, tex_u, tex_v, corner, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/gqlay_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gqlay_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/gqlay_front.sv
// Front end: accepts requests, loads the glyph tables, tracks string state
// and queues glyph and newline work. Depends on gqlay_pkg, gqlay_if, gqlay_ram.
`default_nettype none

module gqlay_front import gqlay_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gqlay_in_if.sink               in_req,
  input  wire logic [QCNT_W-1:0] q_count,
  output      logic              q_push,
  output      q_entry_t          q_data
);

  logic              accept;
  logic              in_range;
  logic              is_char;
  logic [SEEN_W-1:0] seen_r, seen_nxt, eff_seen;
  logic              ended_r, ended_nxt, eff_ended;
  logic              enq, enq_newline;
  logic              s1_valid_r, s1_newline_r, s1_reset_r, s1_oob_r;
  logic [GEOM_W-1:0] geom_rd;
  logic [TEX_W-1:0]  tex_rd;
  geom_t             geom_wr;
  tex_t              tex_wr;

  assign in_req.ready = (q_count + QCNT_W'(s1_valid_r)) < QCNT_W'(QDEPTH);
  assign accept       = in_req.valid && in_req.ready;
  assign is_char      = in_req.operation == OP_CHAR;
  assign in_range     = {1'b0, in_req.char_code} < 9'(GLYPH_COUNT);

  assign geom_wr = '{bx: in_req.bearing_x, by: in_req.bearing_y,
                     w: in_req.glyph_width, h: in_req.glyph_height,
                     adv: in_req.advance};
  assign tex_wr  = '{left: in_req.tex_left, right: in_req.tex_right,
                     top: in_req.tex_top, bottom: in_req.tex_bottom};

  gqlay_ram #(.WIDTH(GEOM_W), .DEPTH(GLYPH_COUNT)) u_geom_ram (
    .clk   (clk),
    .we    (accept && !is_char && in_range),
    .waddr (in_req.char_code[GLYPH_AW-1:0]),
    .wdata (geom_wr),
    .re    (accept && is_char),
    .raddr (in_req.char_code[GLYPH_AW-1:0]),
    .rdata (geom_rd)
  );

  gqlay_ram #(.WIDTH(TEX_W), .DEPTH(GLYPH_COUNT)) u_tex_ram (
    .clk   (clk),
    .we    (accept && !is_char && in_range),
    .waddr (in_req.char_code[GLYPH_AW-1:0]),
    .wdata (tex_wr),
    .re    (accept && is_char),
    .raddr (in_req.char_code[GLYPH_AW-1:0]),
    .rdata (tex_rd)
  );

  always_comb begin
    eff_seen    = in_req.first_of_string ? '0 : seen_r;
    eff_ended   = in_req.first_of_string ? 1'b0 : ended_r;
    seen_nxt    = seen_r;
    ended_nxt   = ended_r;
    enq         = 1'b0;
    enq_newline = 1'b0;
    if (accept && is_char) begin
      seen_nxt  = eff_seen;
      ended_nxt = eff_ended;
      if (!eff_ended) begin
        if (eff_seen >= SEEN_W'(MAX_CHARS)) begin
          ended_nxt = 1'b1;
        end else begin
          seen_nxt = eff_seen + SEEN_W'(1);
          priority if (in_req.char_code == CHAR_NUL) begin
            ended_nxt = 1'b1;
          end else if (in_req.char_code == CHAR_NEWLINE) begin
            enq         = 1'b1;
            enq_newline = 1'b1;
          end else begin
            enq = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      ended_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      ended_r    <= ended_nxt;
      s1_valid_r <= enq;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_newline_r <= enq_newline;
      s1_reset_r   <= in_req.first_of_string;
      s1_oob_r     <= !in_range;
    end
  end

  assign q_push         = s1_valid_r;
  assign q_data.reset_pen = s1_reset_r;
  assign q_data.newline = s1_newline_r;
  assign q_data.geom    = s1_oob_r ? '0 : geom_t'(geom_rd);
  assign q_data.tex     = s1_oob_r ? '0 : tex_t'(tex_rd);

endmodule

`default_nettype wire

### rtl/gqlay_queue.sv
// Small FIFO of classified work between the front and back ends.
// Depends on gqlay_pkg.
`default_nettype none

module gqlay_queue import gqlay_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire q_entry_t          push_data,
  input  wire logic              pop,
  output      q_entry_t          head,
  output      logic [QCNT_W-1:0] count
);

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] count_r;

  assign head  = mem[rp_r];
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### rtl/gqlay_back.sv
// Back end: holds the pen and config registers, runs newlines and emits the
// four vertices of each glyph quad. Depends on gqlay_pkg and gqlay_if.
`default_nettype none

module gqlay_back import gqlay_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_wr_t           cfg,
  input  wire q_entry_t          q_head,
  input  wire logic [QCNT_W-1:0] q_count,
  output      logic              q_pop,
  gqlay_out_if.source            out_req
);

  back_state_t       state_r, state_nxt;
  logic [1:0]        corner_r;
  q_entry_t          cur_r;
  logic [POS_W-1:0]  pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic [15:0]       ascent_r, line_dist_r;
  logic              free, emit, quad_done;
  logic [25:0]       left, right, top, bottom;
  logic              out_valid_r;
  logic [POS_W-1:0]  pos_x_r, pos_y_r;
  logic [15:0]       tex_u_r, tex_v_r;
  logic [1:0]        corner_out_r;
  logic              last_r;

  function automatic logic [POS_W-1:0] sat24(input logic [25:0] v);
    if (!v[25] && (v[24:23] != 2'b00)) begin
      return 24'h7FFFFF;
    end
    if (v[25] && (v[24:23] != 2'b11)) begin
      return 24'h800000;
    end
    return v[23:0];
  endfunction

  assign left   = {{2{pen_x_r[23]}}, pen_x_r} + {{12{cur_r.geom.bx[7]}}, cur_r.geom.bx, 6'b0};
  assign right  = left + {12'b0, cur_r.geom.w, 6'b0};
  assign top    = {{2{pen_y_r[23]}}, pen_y_r} - {{11{cur_r.geom.by[8]}}, cur_r.geom.by, 6'b0};
  assign bottom = top + {12'b0, cur_r.geom.h, 6'b0};

  // control outputs
  always_comb begin
    emit = (state_r == BK_GLYPH) && (!out_valid_r || out_req.ready);
    quad_done = emit && (corner_r == CORNER_LAST);
    unique case (state_r)
      BK_IDLE:    free = 1'b1;
      BK_NEWLINE: free = 1'b1;
      BK_GLYPH:   free = quad_done;
      default:    free = 1'b0;
    endcase
    q_pop = free && (q_count != '0);
  end

  // next state
  always_comb begin
    priority if (q_pop) begin
      state_nxt = q_head.newline ? BK_NEWLINE : BK_GLYPH;
    end else if (free) begin
      state_nxt = BK_IDLE;
    end else begin
      state_nxt = state_r;
    end
  end

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (state_r == BK_NEWLINE) begin
      pen_x_nxt = '0;
      pen_y_nxt = sat24({{2{pen_y_r[23]}}, pen_y_r} + {10'b0, line_dist_r});
    end
    if (quad_done) begin
      pen_x_nxt = sat24({{2{pen_x_r[23]}}, pen_x_r} + {12'b0, cur_r.geom.adv});
    end
    if (q_pop && q_head.reset_pen) begin
      pen_x_nxt = '0;
      pen_y_nxt = {8'b0, ascent_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      corner_r    <= '0;
      pen_x_r     <= '0;
      pen_y_r     <= {8'b0, ASCENT_RESET};
      ascent_r    <= ASCENT_RESET;
      line_dist_r <= LINE_DIST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      if (q_pop) begin
        corner_r <= '0;
      end else if (emit) begin
        corner_r <= corner_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg.we) begin
        unique case (cfg.idx)
          REG_ASCENT:    ascent_r    <= cfg.data;
          REG_LINE_DIST: line_dist_r <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (emit) begin
      pos_x_r      <= corner_r[0] ? sat24(right) : sat24(left);
      pos_y_r      <= corner_r[1] ? sat24(bottom) : sat24(top);
      tex_u_r      <= corner_r[0] ? cur_r.tex.right : cur_r.tex.left;
      tex_v_r      <= corner_r[1] ? cur_r.tex.bottom : cur_r.tex.top;
      corner_out_r <= corner_r;
      last_r       <= corner_r == CORNER_LAST;
    end
  end

  assign out_req.valid  = out_valid_r;
  assign out_req.pos_x  = pos_x_r;
  assign out_req.pos_y  = pos_y_r;
  assign out_req.tex_u  = tex_u_r;
  assign out_req.tex_v  = tex_v_r;
  assign out_req.corner = corner_out_r;
  assign out_req.last   = last_r;

endmodule

`default_nettype wire

### rtl/glyph_quad_layout.sv
// Top level of the glyph quad layout block: front end, work queue, back end.
// Depends on gqlay_pkg, gqlay_if, gqlay_front, gqlay_queue, gqlay_back.
//
// Load requests write one glyph table entry. Character requests are taken one
// per cycle until the four-entry work queue fills; a glyph then occupies the
// back end for its four vertices, one vertex per cycle while the output is not
// stalled, through the single output register; a newline has a back-end state
// of its own. A first vertex passes the registered table read, the work queue,
// the current-glyph register and the output register. The glyph tables power
// up unknown and need no clearing; config writes belong in idle periods.
`default_nettype none

module glyph_quad_layout import gqlay_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gqlay_in_if.sink                   in_req,
  gqlay_out_if.source                out_req,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_wr_t           cfg_wr;
  logic              q_push, q_pop;
  q_entry_t          q_data, q_head;
  logic [QCNT_W-1:0] q_count;

  assign cfg_wr = '{we: cfg_we, idx: cfg_index, data: cfg_wdata};

  gqlay_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  gqlay_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count)
  );

  gqlay_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_wr),
    .q_head  (q_head),
    .q_count (q_count),
    .q_pop   (q_pop),
    .out_req (out_req)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < QCNT_W'(QDEPTH)))
    else $error("push into full work queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != '0))
    else $error("pop from empty work queue");

  a_quad_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_req.valid && out_req.ready && out_req.last) |=>
      (!out_req.valid || (out_req.corner == 2'd0)))
    else $error("quad does not restart at corner 0");
`endif

endmodule

`default_nettype wire

### test/glyph_quad_layout_tb.sv
// Testbench for glyph_quad_layout: loads glyph metrics, lays out strings and checks
// every emitted vertex against a built-in pen and quad predictor.
// Depends on gqlay_pkg, the gqlay_in_if / gqlay_out_if interfaces and glyph_quad_layout.
`timescale 1ns / 1ps

module glyph_quad_layout_tb;
  import gqlay_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASES   = 4;
  localparam int PHASE_ITEMS     = 25;

  localparam cfg_idx_t   REG_UNUSED = 2'd3;
  localparam logic [1:0] CORNER_TL  = 2'd0;
  localparam logic [1:0] CORNER_TR  = 2'd1;
  localparam logic [1:0] CORNER_BL  = 2'd2;

  localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_LO = -(longint'(1) << (POS_W - 1));

  typedef struct {
    logic       operation;
    logic       first;
    logic [7:0] code;
    geom_t      geom;
    tex_t       tex;
  } glyph_req_t;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [15:0]             tex_u;
    logic [15:0]             tex_v;
    logic [1:0]              corner;
    logic                    last;
  } vertex_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gqlay_in_if  in_ch ();
  gqlay_out_if out_ch ();

  glyph_quad_layout dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_req   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // layout predictor state
  geom_t                   geom_tbl [GLYPH_COUNT];
  tex_t                    tex_tbl [GLYPH_COUNT];
  bit                      glyph_loaded [GLYPH_COUNT];
  logic [7:0]              glyph_codes [$];
  logic [15:0]             ascent_reg;
  logic [15:0]             line_dist_reg;
  logic signed [POS_W-1:0] pen_x;
  logic signed [POS_W-1:0] pen_y;
  int                      chars_seen;
  bit                      string_ended;
  vertex_t                 vertex_q [$];

  int err_cnt     = 0;
  int cycle_cnt   = 0;
  int burst_left  = 0;
  bit sender_gaps = 1'b1;
  int hold_req    = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [POS_W-1:0] sat_pos(input longint v);
    logic signed [POS_W-1:0] s;
    if (v > POS_HI) v = POS_HI;
    if (v < POS_LO) v = POS_LO;
    s = v[POS_W-1:0];
    return s;
  endfunction

  function automatic void push_vertex(input longint x, input longint y,
                                      input logic [15:0] u, input logic [15:0] v,
                                      input logic [1:0] c);
    vertex_t e;
    e.pos_x  = sat_pos(x);
    e.pos_y  = sat_pos(y);
    e.tex_u  = u;
    e.tex_v  = v;
    e.corner = c;
    e.last   = (c == CORNER_LAST);
    vertex_q.push_back(e);
  endfunction

  function automatic void apply_req(input glyph_req_t r);
    geom_t  g;
    tex_t   t;
    longint left, right, top, bottom;
    if (r.operation == OP_LOAD) begin
      if (int'(r.code) < GLYPH_COUNT) begin
        geom_tbl[r.code] = r.geom;
        tex_tbl[r.code]  = r.tex;
        if (!glyph_loaded[r.code] && r.code != CHAR_NUL && r.code != CHAR_NEWLINE)
          glyph_codes.push_back(r.code);
        glyph_loaded[r.code] = 1'b1;
      end
      return;
    end
    if (r.first) begin
      pen_x        = '0;
      pen_y        = sat_pos(longint'(ascent_reg));
      chars_seen   = 0;
      string_ended = 1'b0;
    end
    if (string_ended) return;
    if (chars_seen >= MAX_CHARS) begin
      string_ended = 1'b1;
      return;
    end
    chars_seen++;
    if (r.code == CHAR_NUL) begin
      string_ended = 1'b1;
      return;
    end
    if (r.code == CHAR_NEWLINE) begin
      pen_x = '0;
      pen_y = sat_pos(longint'(pen_y) + longint'(line_dist_reg));
      return;
    end
    g      = geom_tbl[r.code];
    t      = tex_tbl[r.code];
    left   = longint'(pen_x) + 64 * longint'($signed(g.bx));
    right  = left + 64 * longint'(g.w);
    top    = longint'(pen_y) - 64 * longint'($signed(g.by));
    bottom = top + 64 * longint'(g.h);
    push_vertex(left,  top,    t.left,  t.top,    CORNER_TL);
    push_vertex(right, top,    t.right, t.top,    CORNER_TR);
    push_vertex(left,  bottom, t.left,  t.bottom, CORNER_BL);
    push_vertex(right, bottom, t.right, t.bottom, CORNER_LAST);
    pen_x = sat_pos(longint'(pen_x) + longint'(g.adv));
  endfunction

  function automatic glyph_req_t rand_req();
    glyph_req_t  r;
    logic [63:0] rnd;
    rnd         = {$urandom(), $urandom()};
    r.operation = 1'($urandom_range(0, 1));
    r.first     = 1'($urandom_range(0, 1));
    r.code      = 8'($urandom_range(0, 255));
    r.geom      = rnd[GEOM_W-1:0];
    r.tex       = {$urandom(), $urandom()};
    return r;
  endfunction

  function automatic logic [7:0] pick_glyph();
    return glyph_codes[$urandom_range(0, glyph_codes.size() - 1)];
  endfunction

  // Called at a falling edge or right after an accepted request; returns at the
  // rising edge that accepts this one.
  task automatic send_req(input glyph_req_t r);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      if (sender_gaps) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.operation       = r.operation;
    in_ch.first_of_string = r.first;
    in_ch.char_code       = r.code;
    in_ch.bearing_x       = r.geom.bx;
    in_ch.bearing_y       = r.geom.by;
    in_ch.glyph_width     = r.geom.w;
    in_ch.glyph_height    = r.geom.h;
    in_ch.advance         = r.geom.adv;
    in_ch.tex_left        = r.tex.left;
    in_ch.tex_right       = r.tex.right;
    in_ch.tex_top         = r.tex.top;
    in_ch.tex_bottom      = r.tex.bottom;
    in_ch.valid           = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_req(r);
  endtask

  task automatic send_load(input logic [7:0] code, input geom_t g, input tex_t t);
    glyph_req_t r;
    r           = rand_req();
    r.operation = OP_LOAD;
    r.code      = code;
    r.geom      = g;
    r.tex       = t;
    send_req(r);
  endtask

  task automatic send_char(input logic [7:0] code, input logic first);
    glyph_req_t r;
    r           = rand_req();
    r.operation = OP_CHAR;
    r.code      = code;
    r.first     = first;
    send_req(r);
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (vertex_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only while idle
  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_ASCENT) ascent_reg = data;
    else if (idx == REG_LINE_DIST) line_dist_reg = data;
  endtask

  // first string after reset starts from the reset pen without first_of_string
  task automatic test_reset_pen();
    send_load(8'd65, geom_t'(GEOM_W'({$urandom(), $urandom()})),
              tex_t'({$urandom(), $urandom()}));
    send_char(8'd65, 1'b0);
    send_char(8'd65, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_load(8'd255, geom_t'{-8'sd128, 9'sd255, 8'd255, 8'd255, 14'h3fff}, '1);
    send_load(8'd1, geom_t'{8'sd127, -9'sd256, 8'd0, 8'd0, 14'd0}, '0);
    send_load(CHAR_NUL, geom_t'(GEOM_W'({$urandom(), $urandom()})),
              tex_t'({$urandom(), $urandom()}));
    send_load(CHAR_NEWLINE, geom_t'(GEOM_W'({$urandom(), $urandom()})),
              tex_t'({$urandom(), $urandom()}));
    send_char(8'd255, 1'b1);
    send_char(8'd1, 1'b0);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char(8'd255, 1'b0);
    send_char(CHAR_NUL, 1'b0);
    send_char(8'd1, 1'b0);
    send_char(8'd1, 1'b1);
    send_char(8'd255, 1'b0);
  endtask

  // pen holds across writes; ascent applies at the next string start
  task automatic test_config_settings();
    drain_block();
    cfg_write(REG_ASCENT, 16'd0);
    cfg_write(REG_LINE_DIST, 16'hffff);
    cfg_write(REG_UNUSED, 16'($urandom()));
    send_char(8'd65, 1'b1);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char(8'd1, 1'b0);
    drain_block();
    cfg_write(REG_ASCENT, 16'hffff);
    cfg_write(REG_LINE_DIST, 16'd0);
    send_char(8'd255, 1'b0);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(8'd65, 1'b1);
  endtask

  // full-length string of newlines drives the last quad into saturation
  task automatic test_length_limit();
    drain_block();
    cfg_write(REG_ASCENT, 16'hffff);
    cfg_write(REG_LINE_DIST, 16'hffff);
    send_load(8'd2, geom_t'{8'sd127, -9'sd256, 8'd255, 8'd255, 14'd100},
              tex_t'({$urandom(), $urandom()}));
    send_char(CHAR_NEWLINE, 1'b1);
    repeat (MAX_CHARS - 2) send_char(CHAR_NEWLINE, 1'b0);
    send_char(8'd2, 1'b0);
    send_char(8'd2, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char(8'd2, 1'b1);
  endtask

  task automatic test_input_stall();
    drain_block();
    sender_gaps = 1'b0;
    hold_req    = HOLD_OFF_CYCLES;
    send_char(pick_glyph(), 1'b1);
    repeat (15) send_char(pick_glyph(), 1'b0);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_strings();
    glyph_req_t r;
    int         k;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_block();
      case (p)
        0: begin
          cfg_write(REG_ASCENT, 16'd0);
          cfg_write(REG_LINE_DIST, 16'd0);
        end
        1: begin
          cfg_write(REG_ASCENT, 16'hffff);
          cfg_write(REG_LINE_DIST, 16'hffff);
        end
        default: begin
          cfg_write(REG_ASCENT, 16'($urandom()));
          cfg_write(REG_LINE_DIST, 16'($urandom()));
        end
      endcase
      sender_gaps = (p != 2);
      send_char(pick_glyph(), 1'b1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        k = $urandom_range(0, 99);
        if (k < 20) begin
          r           = rand_req();
          r.operation = OP_LOAD;
          send_req(r);
        end else begin
          r           = rand_req();
          r.operation = OP_CHAR;
          r.code      = pick_glyph();
          r.first     = (k < 27);
          k = $urandom_range(0, 99);
          if (k < 8) r.code = CHAR_NEWLINE;
          else if (k < 11) r.code = CHAR_NUL;
          send_req(r);
        end
      end
    end
    sender_gaps = 1'b1;
  endtask

  // result sink: stall pattern of its own, plus a long hold-off on request
  initial begin : vertex_sink
    int stall_pct;
    int mode_left;
    int hold_n;
    stall_pct    = 0;
    mode_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_n       = hold_req;
        hold_req     = 0;
        out_ch.ready = 1'b0;
        repeat (hold_n - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
          mode_left = $urandom_range(8, 40);
        end
        mode_left--;
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : vertex_check
    vertex_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex: pos_x %0d pos_y %0d corner %0d",
               out_ch.pos_x, out_ch.pos_y, out_ch.corner);
        err_cnt++;
      end else begin
        e = vertex_q.pop_front();
        if (out_ch.pos_x !== e.pos_x) begin
          $error("pos_x expected %0d got %0d", e.pos_x, out_ch.pos_x);
          err_cnt++;
        end
        if (out_ch.pos_y !== e.pos_y) begin
          $error("pos_y expected %0d got %0d", e.pos_y, out_ch.pos_y);
          err_cnt++;
        end
        if (out_ch.tex_u !== e.tex_u) begin
          $error("tex_u expected %0d got %0d", e.tex_u, out_ch.tex_u);
          err_cnt++;
        end
        if (out_ch.tex_v !== e.tex_v) begin
          $error("tex_v expected %0d got %0d", e.tex_v, out_ch.tex_v);
          err_cnt++;
        end
        if (out_ch.corner !== e.corner) begin
          $error("corner expected %0d got %0d", e.corner, out_ch.corner);
          err_cnt++;
        end
        if (out_ch.last !== e.last) begin
          $error("last expected %0d got %0d", e.last, out_ch.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.operation       = OP_LOAD;
    in_ch.first_of_string = 1'b0;
    in_ch.char_code       = '0;
    in_ch.bearing_x       = '0;
    in_ch.bearing_y       = '0;
    in_ch.glyph_width     = '0;
    in_ch.glyph_height    = '0;
    in_ch.advance         = '0;
    in_ch.tex_left        = '0;
    in_ch.tex_right       = '0;
    in_ch.tex_top         = '0;
    in_ch.tex_bottom      = '0;
    cfg_we                = 1'b0;
    cfg_index             = REG_ASCENT;
    cfg_wdata             = '0;
    ascent_reg            = ASCENT_RESET;
    line_dist_reg         = LINE_DIST_RESET;
    pen_x                 = '0;
    pen_y                 = sat_pos(longint'(ASCENT_RESET));
    chars_seen            = 0;
    string_ended          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_pen();
    test_field_extremes();
    test_config_settings();
    test_length_limit();
    test_input_stall();
    test_random_strings();

    drain_block();
    if (vertex_q.size() != 0) begin
      $error("%0d vertices never arrived", vertex_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/gqlay_pkg.sv
rtl/gqlay_if.sv
rtl/gqlay_ram.sv
rtl/gqlay_front.sv
rtl/gqlay_queue.sv
rtl/gqlay_back.sv
rtl/glyph_quad_layout.sv
test/glyph_quad_layout_tb.sv
